// ===== hw/rtl/dctp_pkg.sv =====
// Package for the disk collision time predictor: field widths, request and
// register codes, reset values and the structs that travel down the pipeline.
// Depends on nothing; the top level refers to it by scoped names.
`default_nettype none

package dctp_pkg;

   // Request kinds carried by req_type.
   localparam logic [1:0] REQ_DISK   = 2'd0;
   localparam logic [1:0] REQ_WALL_X = 2'd1;
   localparam logic [1:0] REQ_WALL_Y = 2'd2;
   localparam logic [1:0] REQ_UNUSED = 2'd3;

   // Configuration register indexes.
   localparam logic [1:0] CSR_BOX_LENGTH      = 2'd0;
   localparam logic [1:0] CSR_BOX_WIDTH       = 2'd1;
   localparam logic [1:0] CSR_PARTICLE_RADIUS = 2'd2;

   localparam logic [31:0] RST_BOX_LENGTH      = 32'd6553600;
   localparam logic [31:0] RST_BOX_WIDTH       = 32'd6553600;
   localparam logic [31:0] RST_PARTICLE_RADIUS = 32'd65536;

   localparam int unsigned WORD_W  = 32;
   localparam int unsigned DIFF_W  = 33;   // difference of two coordinates
   localparam int unsigned PROD_W  = 66;   // product of two differences
   localparam int unsigned DOT_W   = 67;   // signed dot product
   localparam int unsigned MAG_W   = 66;   // magnitude of a dot product
   localparam int unsigned HALF_W  = 33;   // half of a magnitude for split products
   localparam int unsigned DISC_W  = 132;  // magnitude of the discriminant
   localparam int unsigned ROOT_W  = 66;   // integer square root of it
   localparam int unsigned REM_W   = 68;   // square root partial remainder
   localparam int unsigned WALL_W  = 35;   // signed wall distance
   localparam int unsigned DIV_W   = 98;   // divider working width
   localparam int unsigned TIME_W  = 32;

   localparam logic [TIME_W-1:0] TIME_MAX = '1;

   typedef struct packed {
      logic                  is_disk;
      logic                  pre_miss;   // no hit known before any arithmetic
      logic                  pre_zero;   // wall already reached: time is zero
      logic [WALL_W-2:0]     wall_num;
      logic [WORD_W-1:0]     wall_den;
   } base_type;

   typedef struct packed {
      base_type              base;
      logic                  disk_ok;
      logic [MAG_W-1:0]      mag;        // |dv.dr| when dv.dr is negative
      logic [MAG_W-1:0]      dvdv;
   } carry_type;

   typedef struct packed {
      carry_type             c;
      logic [DISC_W-1:0]     rad;
      logic [REM_W-1:0]      rem;
      logic [ROOT_W-1:0]     root;
   } sqrt_type;

   typedef struct packed {
      logic                  live;
      logic                  zero;
      logic                  sat;
      logic [MAG_W-1:0]      den;
      logic [DIV_W-1:0]      rem;
      logic [TIME_W-1:0]     quo;
   } div_type;

endpackage

`default_nettype wire

// ===== hw/rtl/disk_collision_time_predictor.sv =====
// Top level of the disk collision time predictor: a fully pipelined datapath
// with square root and divider stages. Depends on dctp_pkg.
`default_nettype none

// One item enters per clock cycle while no result is stalled; the
// depth is set by the integer square root of the 132-bit discriminant, which
// settles one root bit per stage (66 stages), and by the restoring divider,
// which settles one quotient bit per stage (32 stages). The front end takes
// eight stages for the differences, the dot products, the split wide products
// and the discriminant, and two more stages prepare the division. The whole
// pipeline, the output register included, freezes while a waiting result is
// stalled, so req_stall follows rsp_stall whenever a result is held. Disk
// requests report no hit when the disks separate, have no relative motion, miss
// each other or would touch at a time that is not positive; wall requests report
// no hit only for a zero velocity component, and a time of zero once the wall
// lies behind. Times are unsigned fixed point with FRAC_BITS fraction bits,
// rounded toward zero and saturated at all ones. Configuration registers are
// sampled as an item enters and are to be written only while the block is idle.
module disk_collision_time_predictor #(
   parameter int unsigned FRAC_BITS = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   // configuration
   input  wire logic               csr_write_enable,
   input  wire logic [1:0]         csr_index,
   input  wire logic [31:0]        csr_write_data,
   // request channel
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [1:0]         req_type,
   input  wire logic signed [31:0] req_first_pos_x,
   input  wire logic signed [31:0] req_first_pos_y,
   input  wire logic signed [31:0] req_first_vel_x,
   input  wire logic signed [31:0] req_first_vel_y,
   input  wire logic signed [31:0] req_second_pos_x,
   input  wire logic signed [31:0] req_second_pos_y,
   input  wire logic signed [31:0] req_second_vel_x,
   input  wire logic signed [31:0] req_second_vel_y,
   input  wire logic [31:0]        req_contact_distance,
   // result channel
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic                    rsp_hit,
   output logic [31:0]             rsp_time_to_hit
);

   localparam int unsigned DIFF_W = dctp_pkg::DIFF_W;
   localparam int unsigned PROD_W = dctp_pkg::PROD_W;
   localparam int unsigned DOT_W  = dctp_pkg::DOT_W;
   localparam int unsigned MAG_W  = dctp_pkg::MAG_W;
   localparam int unsigned HALF_W = dctp_pkg::HALF_W;
   localparam int unsigned DISC_W = dctp_pkg::DISC_W;
   localparam int unsigned ROOT_W = dctp_pkg::ROOT_W;
   localparam int unsigned REM_W  = dctp_pkg::REM_W;
   localparam int unsigned WALL_W = dctp_pkg::WALL_W;
   localparam int unsigned DIV_W  = dctp_pkg::DIV_W;
   localparam int unsigned TIME_W = dctp_pkg::TIME_W;

   // The pipeline moves whenever the output register is free or being taken.
   logic adv;
   assign adv       = !(rsp_valid && rsp_stall);
   assign req_stall = !adv;

   // ---------------------------------------------------------------------
   // Configuration registers.
   logic [31:0] box_length_ff, box_width_ff, particle_radius_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         box_length_ff      <= dctp_pkg::RST_BOX_LENGTH;
         box_width_ff       <= dctp_pkg::RST_BOX_WIDTH;
         particle_radius_ff <= dctp_pkg::RST_PARTICLE_RADIUS;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            dctp_pkg::CSR_BOX_LENGTH:      box_length_ff      <= csr_write_data;
            dctp_pkg::CSR_BOX_WIDTH:       box_width_ff       <= csr_write_data;
            dctp_pkg::CSR_PARTICLE_RADIUS: particle_radius_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Stage 1: coordinate differences and the whole wall set-up.
   logic                       p1_valid_ff;
   dctp_pkg::base_type         p1_base_ff, p1_base_in;
   logic signed [DIFF_W-1:0]   p1_drx_ff, p1_dry_ff, p1_dvx_ff, p1_dvy_ff;
   logic [31:0]                p1_sig_ff;

   always_comb begin
      logic signed [31:0]       pos, vel;
      logic [31:0]              ext, vel_u;
      logic                     is_wall;
      logic signed [WALL_W-1:0] n_pos, n_neg, n;
      pos     = req_first_pos_x;
      vel     = req_first_vel_x;
      ext     = box_length_ff;
      is_wall = 1'b0;
      unique case (req_type)
         dctp_pkg::REQ_WALL_X: begin
            is_wall = 1'b1;
         end
         dctp_pkg::REQ_WALL_Y: begin
            is_wall = 1'b1;
            pos     = req_first_pos_y;
            vel     = req_first_vel_y;
            ext     = box_width_ff;
         end
         default: ;
      endcase
      n_pos = WALL_W'($signed({1'b0, ext})) - WALL_W'($signed({1'b0, particle_radius_ff}))
              - WALL_W'(pos);
      n_neg = WALL_W'(pos) - WALL_W'($signed({1'b0, particle_radius_ff}));
      n     = vel[31] ? n_neg : n_pos;
      vel_u = vel;
      p1_base_in.is_disk  = (req_type == dctp_pkg::REQ_DISK);
      p1_base_in.pre_miss = !(is_wall || req_type == dctp_pkg::REQ_DISK)
                            || (is_wall && vel == 32'sd0);
      p1_base_in.pre_zero = is_wall && (n <= 0);
      p1_base_in.wall_num = n[WALL_W-2:0];
      p1_base_in.wall_den = vel[31] ? (~vel_u + 32'd1) : vel_u;
   end

   always_ff @(posedge clock) begin
      if (reset) p1_valid_ff <= 1'b0;
      else if (adv) p1_valid_ff <= req_valid;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p1_base_ff <= p1_base_in;
         p1_drx_ff  <= DIFF_W'(req_second_pos_x) - DIFF_W'(req_first_pos_x);
         p1_dry_ff  <= DIFF_W'(req_second_pos_y) - DIFF_W'(req_first_pos_y);
         p1_dvx_ff  <= DIFF_W'(req_second_vel_x) - DIFF_W'(req_first_vel_x);
         p1_dvy_ff  <= DIFF_W'(req_second_vel_y) - DIFF_W'(req_first_vel_y);
         p1_sig_ff  <= req_contact_distance;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 2: the six component products and the squared contact distance.
   logic                       p2_valid_ff;
   dctp_pkg::base_type         p2_base_ff;
   logic signed [PROD_W-1:0]   p2_vrx_ff, p2_vry_ff, p2_vvx_ff, p2_vvy_ff;
   logic signed [PROD_W-1:0]   p2_rrx_ff, p2_rry_ff;
   logic [63:0]                p2_sig2_ff;

   always_ff @(posedge clock) begin
      if (reset) p2_valid_ff <= 1'b0;
      else if (adv) p2_valid_ff <= p1_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p2_base_ff <= p1_base_ff;
         p2_vrx_ff  <= p1_dvx_ff * p1_drx_ff;
         p2_vry_ff  <= p1_dvy_ff * p1_dry_ff;
         p2_vvx_ff  <= p1_dvx_ff * p1_dvx_ff;
         p2_vvy_ff  <= p1_dvy_ff * p1_dvy_ff;
         p2_rrx_ff  <= p1_drx_ff * p1_drx_ff;
         p2_rry_ff  <= p1_dry_ff * p1_dry_ff;
         p2_sig2_ff <= p1_sig_ff * p1_sig_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 3: dot products.
   logic                       p3_valid_ff;
   dctp_pkg::base_type         p3_base_ff;
   logic signed [DOT_W-1:0]    p3_dvdr_ff;
   logic [MAG_W-1:0]           p3_dvdv_ff, p3_dr2_ff;
   logic [63:0]                p3_sig2_ff;

   always_ff @(posedge clock) begin
      if (reset) p3_valid_ff <= 1'b0;
      else if (adv) p3_valid_ff <= p2_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p3_base_ff <= p2_base_ff;
         p3_dvdr_ff <= DOT_W'(p2_vrx_ff) + DOT_W'(p2_vry_ff);
         p3_dvdv_ff <= $unsigned(p2_vvx_ff) + $unsigned(p2_vvy_ff);
         p3_dr2_ff  <= $unsigned(p2_rrx_ff) + $unsigned(p2_rry_ff);
         p3_sig2_ff <= p2_sig2_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 4: magnitude of an approaching dv.dr, and c = dr.dr - sigma^2.
   logic                       p4_valid_ff;
   dctp_pkg::carry_type        p4_carry_ff, p4_carry_in;
   logic signed [DOT_W-1:0]    p4_c_ff;

   always_comb begin
      p4_carry_in.base    = p3_base_ff;
      p4_carry_in.disk_ok = p3_dvdr_ff[DOT_W-1] && (p3_dvdv_ff != '0);
      p4_carry_in.mag     = p3_dvdr_ff[DOT_W-1] ? MAG_W'(-p3_dvdr_ff) : '0;
      p4_carry_in.dvdv    = p3_dvdv_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) p4_valid_ff <= 1'b0;
      else if (adv) p4_valid_ff <= p3_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p4_carry_ff <= p4_carry_in;
         p4_c_ff     <= DOT_W'($signed({1'b0, p3_dr2_ff})) - DOT_W'($signed({1'b0, p3_sig2_ff}));
      end
   end

   // ---------------------------------------------------------------------
   // Stage 5: sign and magnitude of c.
   logic                       p5_valid_ff;
   dctp_pkg::carry_type        p5_carry_ff;
   logic [MAG_W-1:0]           p5_cmag_ff;
   logic                       p5_cneg_ff;

   always_ff @(posedge clock) begin
      if (reset) p5_valid_ff <= 1'b0;
      else if (adv) p5_valid_ff <= p4_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p5_carry_ff <= p4_carry_ff;
         p5_cneg_ff  <= p4_c_ff[DOT_W-1];
         p5_cmag_ff  <= p4_c_ff[DOT_W-1] ? MAG_W'(-p4_c_ff) : MAG_W'(p4_c_ff);
      end
   end

   // ---------------------------------------------------------------------
   // Stage 6: the two wide products as 33 by 33 bit partial products.
   logic                       p6_valid_ff;
   dctp_pkg::carry_type        p6_carry_ff;
   logic                       p6_cneg_ff;
   logic [2*HALF_W-1:0]        p6_mm_ll_ff, p6_mm_hl_ff, p6_mm_hh_ff;
   logic [2*HALF_W-1:0]        p6_vc_ll_ff, p6_vc_lh_ff, p6_vc_hl_ff, p6_vc_hh_ff;

   always_ff @(posedge clock) begin
      if (reset) p6_valid_ff <= 1'b0;
      else if (adv) p6_valid_ff <= p5_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p6_carry_ff <= p5_carry_ff;
         p6_cneg_ff  <= p5_cneg_ff;
         p6_mm_ll_ff <= p5_carry_ff.mag[HALF_W-1:0] * p5_carry_ff.mag[HALF_W-1:0];
         p6_mm_hl_ff <= p5_carry_ff.mag[MAG_W-1:HALF_W] * p5_carry_ff.mag[HALF_W-1:0];
         p6_mm_hh_ff <= p5_carry_ff.mag[MAG_W-1:HALF_W] * p5_carry_ff.mag[MAG_W-1:HALF_W];
         p6_vc_ll_ff <= p5_carry_ff.dvdv[HALF_W-1:0] * p5_cmag_ff[HALF_W-1:0];
         p6_vc_lh_ff <= p5_carry_ff.dvdv[HALF_W-1:0] * p5_cmag_ff[MAG_W-1:HALF_W];
         p6_vc_hl_ff <= p5_carry_ff.dvdv[MAG_W-1:HALF_W] * p5_cmag_ff[HALF_W-1:0];
         p6_vc_hh_ff <= p5_carry_ff.dvdv[MAG_W-1:HALF_W] * p5_cmag_ff[MAG_W-1:HALF_W];
      end
   end

   // ---------------------------------------------------------------------
   // Stage 7: (dv.dr)^2 and |(dv.dv) * c| assembled from the partials.
   logic                       p7_valid_ff;
   dctp_pkg::carry_type        p7_carry_ff;
   logic                       p7_cneg_ff;
   logic [DISC_W-1:0]          p7_d1_ff, p7_d2_ff;

   always_ff @(posedge clock) begin
      if (reset) p7_valid_ff <= 1'b0;
      else if (adv) p7_valid_ff <= p6_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p7_carry_ff <= p6_carry_ff;
         p7_cneg_ff  <= p6_cneg_ff;
         // The cross term of a square appears twice, hence the extra shift.
         p7_d1_ff    <= (DISC_W'(p6_mm_hh_ff) << (2*HALF_W))
                        + (DISC_W'(p6_mm_hl_ff) << (HALF_W+1))
                        + DISC_W'(p6_mm_ll_ff);
         p7_d2_ff    <= (DISC_W'(p6_vc_hh_ff) << (2*HALF_W))
                        + ((DISC_W'(p6_vc_hl_ff) + DISC_W'(p6_vc_lh_ff)) << HALF_W)
                        + DISC_W'(p6_vc_ll_ff);
      end
   end

   // ---------------------------------------------------------------------
   // Stage 8 feeds the square root: disc = d1 - (dv.dv) * c.
   // Square root stage k holds the root after k bits have been settled.
   logic                       sq_v_ff [0:ROOT_W];
   dctp_pkg::sqrt_type         sq_ff   [0:ROOT_W];
   dctp_pkg::sqrt_type         sq_in   [0:ROOT_W];

   always_comb begin
      logic [DISC_W:0]  disc;
      logic [REM_W+1:0] t, trial;
      logic             ge;
      disc = p7_cneg_ff ? ({1'b0, p7_d1_ff} + {1'b0, p7_d2_ff})
                        : ({1'b0, p7_d1_ff} - {1'b0, p7_d2_ff});
      sq_in[0].c         = p7_carry_ff;
      sq_in[0].c.disk_ok = p7_carry_ff.disk_ok && !disc[DISC_W];
      sq_in[0].rad       = disc[DISC_W-1:0];
      sq_in[0].rem       = '0;
      sq_in[0].root      = '0;
      for (int k = 0; k < ROOT_W; k++) begin
         t     = {sq_ff[k].rem, sq_ff[k].rad[DISC_W-1 -: 2]};
         trial = (REM_W+2)'({sq_ff[k].root, 2'b01});
         ge    = (t >= trial);
         sq_in[k+1].c    = sq_ff[k].c;
         sq_in[k+1].rad  = {sq_ff[k].rad[DISC_W-3:0], 2'b00};
         sq_in[k+1].rem  = REM_W'(ge ? (t - trial) : t);
         sq_in[k+1].root = {sq_ff[k].root[ROOT_W-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= ROOT_W; k++) sq_v_ff[k] <= 1'b0;
      end else if (adv) begin
         sq_v_ff[0] <= p7_valid_ff;
         for (int k = 1; k <= ROOT_W; k++) sq_v_ff[k] <= sq_v_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k <= ROOT_W; k++) sq_ff[k] <= sq_in[k];
      end
   end

   // ---------------------------------------------------------------------
   // Division set-up, first stage: hit decision and numerator.
   logic                       e1_valid_ff;
   logic                       e1_live_ff, e1_zero_ff;
   logic [MAG_W-1:0]           e1_num_ff, e1_den_ff;

   always_ff @(posedge clock) begin
      if (reset) e1_valid_ff <= 1'b0;
      else if (adv) e1_valid_ff <= sq_v_ff[ROOT_W];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         e1_live_ff <= !sq_ff[ROOT_W].c.base.pre_miss
                       && (!sq_ff[ROOT_W].c.base.is_disk
                           || (sq_ff[ROOT_W].c.disk_ok
                               && sq_ff[ROOT_W].root < sq_ff[ROOT_W].c.mag));
         e1_zero_ff <= sq_ff[ROOT_W].c.base.pre_zero;
         e1_num_ff  <= sq_ff[ROOT_W].c.base.is_disk
                       ? (sq_ff[ROOT_W].c.mag - sq_ff[ROOT_W].root)
                       : MAG_W'(sq_ff[ROOT_W].c.base.wall_num);
         e1_den_ff  <= sq_ff[ROOT_W].c.base.is_disk
                       ? sq_ff[ROOT_W].c.dvdv
                       : MAG_W'(sq_ff[ROOT_W].c.base.wall_den);
      end
   end

   // ---------------------------------------------------------------------
   // Division set-up, second stage, then one quotient bit per stage.
   // A scaled numerator of at least den * 2^32 saturates the time.
   logic                       dv_v_ff [0:TIME_W];
   dctp_pkg::div_type          dv_ff   [0:TIME_W];
   dctp_pkg::div_type          dv_in   [0:TIME_W];

   always_comb begin
      logic [DIV_W-1:0] x, lim, trial;
      logic             ge;
      x   = DIV_W'(e1_num_ff) << FRAC_BITS;
      lim = DIV_W'(e1_den_ff) << TIME_W;
      dv_in[0].live = e1_live_ff;
      dv_in[0].zero = e1_zero_ff;
      dv_in[0].sat  = (x >= lim);
      dv_in[0].den  = e1_den_ff;
      dv_in[0].rem  = x;
      dv_in[0].quo  = '0;
      for (int j = 0; j < TIME_W; j++) begin
         trial     = DIV_W'(dv_ff[j].den) << (TIME_W-1-j);
         ge        = (dv_ff[j].rem >= trial);
         dv_in[j+1]     = dv_ff[j];
         dv_in[j+1].rem = ge ? (dv_ff[j].rem - trial) : dv_ff[j].rem;
         dv_in[j+1].quo[TIME_W-1-j] = ge;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j <= TIME_W; j++) dv_v_ff[j] <= 1'b0;
      end else if (adv) begin
         dv_v_ff[0] <= e1_valid_ff;
         for (int j = 1; j <= TIME_W; j++) dv_v_ff[j] <= dv_v_ff[j-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int j = 0; j <= TIME_W; j++) dv_ff[j] <= dv_in[j];
      end
   end

   // ---------------------------------------------------------------------
   // Output register.
   logic                       rsp_valid_ff;
   logic                       rsp_hit_ff;
   logic [TIME_W-1:0]          rsp_time_ff;

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (adv) rsp_valid_ff <= dv_v_ff[TIME_W];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_hit_ff  <= dv_ff[TIME_W].live;
         rsp_time_ff <= (!dv_ff[TIME_W].live || dv_ff[TIME_W].zero) ? '0
                        : (dv_ff[TIME_W].sat ? dctp_pkg::TIME_MAX : dv_ff[TIME_W].quo);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_time_to_hit = rsp_time_ff;

`ifndef NO_ASSERTIONS
   a_nohit_zero_time: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_hit_ff |-> rsp_time_ff == '0)
      else $error("result without a hit carries a non-zero time");

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> p1_valid_ff)
      else $error("accepted item did not enter the pipeline");

   a_freeze_holds: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(dv_v_ff[TIME_W]) && $stable(sq_v_ff[ROOT_W]))
      else $error("pipeline moved while the output was stalled");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/dctp_result_checker.sv =====
// Result checker for the disk collision time predictor: watches the request,
// result and configuration ports, predicts each result and compares it.
// Depends on dctp_pkg for the request kinds and register indexes.
`timescale 1ns / 100ps

module dctp_result_checker (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_write_enable,
   input  wire logic [1:0]         csr_index,
   input  wire logic [31:0]        csr_write_data,
   input  wire logic               req_valid,
   input  wire logic               req_stall,
   input  wire logic [1:0]         req_type,
   input  wire logic signed [31:0] req_first_pos_x,
   input  wire logic signed [31:0] req_first_pos_y,
   input  wire logic signed [31:0] req_first_vel_x,
   input  wire logic signed [31:0] req_first_vel_y,
   input  wire logic signed [31:0] req_second_pos_x,
   input  wire logic signed [31:0] req_second_pos_y,
   input  wire logic signed [31:0] req_second_vel_x,
   input  wire logic signed [31:0] req_second_vel_y,
   input  wire logic [31:0]        req_contact_distance,
   input  wire logic               rsp_valid,
   input  wire logic               rsp_stall,
   input  wire logic               rsp_hit,
   input  wire logic [31:0]        rsp_time_to_hit,
   output int                      pending_times,
   output int                      mismatch_count
);

   localparam int FRAC = 16;

   typedef logic signed [139:0] wide_type;

   typedef struct packed {
      logic        hit;
      logic [31:0] time_to_hit;
   } contact_type;

   contact_type contact_q[$];
   logic [31:0] box_length_ff, box_width_ff, radius_ff;

   // Exact contact time of two moving disks.
   function automatic contact_type disk_contact(
      input logic signed [31:0] p1x, p1y, v1x, v1y, p2x, p2y, v2x, v2y,
      input logic [31:0] sigma);
      wide_type rx, ry, vx, vy, sig, dvdr, dvdv, sep, disc, root, cand, mag, num, scaled;
      contact_type r;
      r = '0;
      rx = wide_type'(p2x) - wide_type'(p1x);
      ry = wide_type'(p2y) - wide_type'(p1y);
      vx = wide_type'(v2x) - wide_type'(v1x);
      vy = wide_type'(v2y) - wide_type'(v1y);
      sig = wide_type'({108'd0, sigma});
      dvdr = vx * rx + vy * ry;
      dvdv = vx * vx + vy * vy;
      if (dvdr >= 0 || dvdv == 0) return r;
      sep = rx * rx + ry * ry - sig * sig;
      disc = dvdr * dvdr - dvdv * sep;
      if (disc < 0) return r;
      root = 0;
      for (int b = 67; b >= 0; b--) begin
         cand = root | (wide_type'(1) <<< b);
         if (cand * cand <= disc) root = cand;
      end
      mag = -dvdr;
      if (root >= mag) return r;
      num = mag - root;
      scaled = num <<< FRAC;
      r.hit = 1'b1;
      if (scaled >= (dvdv <<< 32)) r.time_to_hit = '1;
      else r.time_to_hit = 32'(scaled / dvdv);
      return r;
   endfunction

   // Time until the disk reaches the wall it is heading for.
   function automatic contact_type wall_contact(input logic signed [31:0] pos, vel,
                                                input logic [31:0] extent);
      longint n, d;
      longint unsigned q;
      contact_type r;
      r = '0;
      if (vel == 0) return r;
      r.hit = 1'b1;
      if (vel > 0) begin
         n = longint'(extent) - longint'(radius_ff) - longint'(pos);
         d = longint'(vel);
      end else begin
         n = longint'(pos) - longint'(radius_ff);
         d = -longint'(vel);
      end
      if (n <= 0) return r;
      q = longint'(unsigned'(n) << FRAC) / longint'(unsigned'(d));
      r.time_to_hit = (q > 64'hFFFF_FFFF) ? '1 : q[31:0];
      return r;
   endfunction

   always @(posedge clock) begin
      contact_type want;
      if (reset) begin
         box_length_ff <= dctp_pkg::RST_BOX_LENGTH;
         box_width_ff  <= dctp_pkg::RST_BOX_WIDTH;
         radius_ff     <= dctp_pkg::RST_PARTICLE_RADIUS;
         contact_q.delete();
         mismatch_count <= 0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               dctp_pkg::CSR_BOX_LENGTH:      box_length_ff <= csr_write_data;
               dctp_pkg::CSR_BOX_WIDTH:       box_width_ff  <= csr_write_data;
               dctp_pkg::CSR_PARTICLE_RADIUS: radius_ff     <= csr_write_data;
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (contact_q.size() == 0) begin
               mismatch_count <= mismatch_count + 1;
               if (mismatch_count < 10)
                  $display("Unexpected result: hit %0d time %h", rsp_hit, rsp_time_to_hit);
            end else begin
               want = contact_q.pop_front();
               if (rsp_hit !== want.hit || rsp_time_to_hit !== want.time_to_hit) begin
                  mismatch_count <= mismatch_count + 1;
                  if (mismatch_count < 10)
                     $display("Mismatch: expected hit %0d time %h, got hit %0d time %h",
                              want.hit, want.time_to_hit, rsp_hit, rsp_time_to_hit);
               end
            end
         end
         if (req_valid && !req_stall) begin
            case (req_type)
               dctp_pkg::REQ_DISK: want = disk_contact(req_first_pos_x, req_first_pos_y,
                  req_first_vel_x, req_first_vel_y, req_second_pos_x, req_second_pos_y,
                  req_second_vel_x, req_second_vel_y, req_contact_distance);
               dctp_pkg::REQ_WALL_X: want = wall_contact(req_first_pos_x, req_first_vel_x,
                                                         box_length_ff);
               dctp_pkg::REQ_WALL_Y: want = wall_contact(req_first_pos_y, req_first_vel_y,
                                                         box_width_ff);
               default: want = '0;
            endcase
            contact_q = {contact_q, want};
         end
      end
      pending_times = contact_q.size();
   end

endmodule

// ===== tb/sv/tb_disk_collision_time_predictor.sv =====
// Testbench top for the disk collision time predictor: drives requests and
// configuration, applies idling and back-pressure, and gives the verdict.
// Depends on dctp_pkg, the block itself and dctp_result_checker.
`timescale 1ns / 100ps

module tb_disk_collision_time_predictor;

   // The block's own latency, with margin, used after the last result.
   localparam int DRAIN_CYCLES = 150;
   localparam int CYCLE_LIMIT  = 2000000;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_write_enable = 1'b0;
   logic [1:0]         csr_index = '0;
   logic [31:0]        csr_write_data = '0;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [1:0]         req_type = '0;
   logic signed [31:0] req_first_pos_x = '0, req_first_pos_y = '0;
   logic signed [31:0] req_first_vel_x = '0, req_first_vel_y = '0;
   logic signed [31:0] req_second_pos_x = '0, req_second_pos_y = '0;
   logic signed [31:0] req_second_vel_x = '0, req_second_vel_y = '0;
   logic [31:0]        req_contact_distance = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic               rsp_hit;
   logic [31:0]        rsp_time_to_hit;

   int pending_times, mismatch_count;
   int gap_percent = 0;     // chance per item that the sender leaves a gap
   int stall_percent = 0;   // chance per cycle that the receiver stalls
   int hold_off_cycles = 0; // a request for one long receiver hold-off
   int cycle_count = 0;

   disk_collision_time_predictor DUT (.*);

   dctp_result_checker checker_i (.*);

   initial begin
      forever #6 clock = ~clock;
   end

   // A cycle counter ends a run that has hung.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // The receiver stalls at random, and once holds off for a long stretch so
   // that the pipeline fills up and the block stalls its input in turn.
   always @(posedge clock) begin
      if (hold_off_cycles > 0) begin
         rsp_stall <= 1'b1;
         hold_off_cycles <= hold_off_cycles - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_percent);
      end
   end

   // Writes one register; the enable drops for a cycle before the next write.
   task automatic write_register(input logic [1:0] index, input logic [31:0] value);
      csr_write_enable <= 1'b1;
      csr_index <= index;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   // Waits until every expected result has come, then lets the pipeline empty.
   task automatic wait_until_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_times != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Offers one item and holds it until the block accepts it. The stall is
   // sampled on the falling edge, where it is settled for the coming edge.
   task automatic offer_item(input logic [1:0] kind,
                             input logic signed [31:0] p1x, p1y, v1x, v1y,
                             input logic signed [31:0] p2x, p2y, v2x, v2y,
                             input logic [31:0] sigma);
      logic stalled;
      while ($urandom_range(99) < gap_percent) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type <= kind;
      req_first_pos_x <= p1x;
      req_first_pos_y <= p1y;
      req_first_vel_x <= v1x;
      req_first_vel_y <= v1y;
      req_second_pos_x <= p2x;
      req_second_pos_y <= p2y;
      req_second_vel_x <= v2x;
      req_second_vel_y <= v2y;
      req_contact_distance <= sigma;
      do begin
         @(negedge clock);
         stalled = req_stall;
         @(posedge clock);
      end while (stalled);
   endtask

   // A value within plus or minus span, in Q16.16.
   function automatic logic signed [31:0] near(input int unsigned span);
      return $signed($urandom_range(2 * span)) - $signed(span);
   endfunction

   // Mostly plausible scenes inside the box, so that disks really meet and
   // walls are ahead, with some raw noise and corner values mixed in.
   task automatic offer_random_item();
      int unsigned pick;
      logic [1:0] kind;
      logic signed [31:0] p2x, p2y;
      pick = $urandom_range(99);
      if ($urandom_range(9) < 6) kind = dctp_pkg::REQ_DISK;
      else kind = ($urandom_range(1) == 0) ? dctp_pkg::REQ_WALL_X : dctp_pkg::REQ_WALL_Y;
      if ($urandom_range(199) == 0) kind = dctp_pkg::REQ_UNUSED;
      if (pick < 65) begin
         p2x = near(32'h0008_0000);
         p2y = near(32'h0008_0000);
         if ($urandom_range(3) == 0)
            // A fixed obstacle: the second disk does not move.
            offer_item(kind, near(32'h0040_0000), near(32'h0040_0000),
                       near(32'h0004_0000), near(32'h0004_0000), p2x, p2y, 0, 0,
                       $urandom_range(32'h0004_0000));
         else
            offer_item(kind, near(32'h0040_0000), near(32'h0040_0000),
                       near(32'h0004_0000), near(32'h0004_0000), p2x, p2y,
                       near(32'h0004_0000), near(32'h0004_0000),
                       $urandom_range(32'h0004_0000));
      end else if (pick < 75) begin
         // Tiny velocities give long times and saturation.
         offer_item(kind, near(32'h0100_0000), near(32'h0100_0000), near(4), near(4),
                    near(32'h0100_0000), near(32'h0100_0000), near(4), near(4),
                    $urandom_range(32'h0200_0000));
      end else begin
         offer_item(kind, $urandom, $urandom, $urandom, $urandom,
                    $urandom, $urandom, $urandom, $urandom, $urandom);
      end
   endtask

   initial begin
      logic [31:0] settings[5][3];
      int gaps[4], stalls[4];
      settings = '{'{dctp_pkg::RST_BOX_LENGTH, dctp_pkg::RST_BOX_WIDTH,
                     dctp_pkg::RST_PARTICLE_RADIUS},
                   '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0},
                   '{32'h0, 32'h0, 32'hFFFF_FFFF},
                   '{32'h0010_0000, 32'h0020_0000, 32'h0000_8000},
                   '{32'h0000_0000, 32'h7FFF_FFFF, 32'h0001_0000}};
      gaps   = '{0, 51, 0, 18};
      stalls = '{0, 0, 51, 18};

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed items: field extremes, every request kind and each named case.
      // Disks closing head on along x.
      offer_item(dctp_pkg::REQ_DISK, 0, 0, 32'h0001_0000, 0, 32'h000A_0000, 0, 0, 0,
                 32'h0002_0000);
      // Separating disks.
      offer_item(dctp_pkg::REQ_DISK, 0, 0, -32'sh0001_0000, 0, 32'h000A_0000, 0, 0, 0,
                 32'h0002_0000);
      // No relative motion.
      offer_item(dctp_pkg::REQ_DISK, 0, 0, 32'h0001_0000, 5, 32'h000A_0000, 0,
                 32'h0001_0000, 5, 32'h0002_0000);
      // Closing but passing wide: negative discriminant.
      offer_item(dctp_pkg::REQ_DISK, 0, 0, 32'h0001_0000, 0, 32'h000A_0000, 32'h0010_0000,
                 0, 0, 32'h0001_0000);
      // Already overlapping while approaching: contact time not positive.
      offer_item(dctp_pkg::REQ_DISK, 0, 0, 32'h0001_0000, 0, 32'h0001_0000, 0, 0, 0,
                 32'h0004_0000);
      // Very fast approach: time rounds down to zero yet is a hit.
      offer_item(dctp_pkg::REQ_DISK, 0, 0, 32'h7FFF_FFFF, 0, 32'h0000_0003, 0,
                 32'h8000_0000, 0, 1);
      // Creeping approach from far away: saturation.
      offer_item(dctp_pkg::REQ_DISK, 32'h8000_0000, 0, 1, 0, 32'h7FFF_FFFF, 0, 0, 0, 0);
      offer_item(dctp_pkg::REQ_DISK, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                 32'h8000_0000, 32'hFFFF_FFFF);
      offer_item(dctp_pkg::REQ_DISK, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                 32'h8000_0000, 32'hFFFF_FFFF);
      // Walls: ahead, behind, at rest, both directions, both axes.
      offer_item(dctp_pkg::REQ_WALL_X, 32'h0032_0000, 0, 32'h0002_0000, 0, 0, 0, 0, 0, 0);
      offer_item(dctp_pkg::REQ_WALL_X, 32'h0032_0000, 0, -32'sh0002_0000, 0, 0, 0, 0, 0, 0);
      offer_item(dctp_pkg::REQ_WALL_X, 32'h0070_0000, 0, 32'h0001_0000, 0, 0, 0, 0, 0, 0);
      offer_item(dctp_pkg::REQ_WALL_X, -32'sh0001_0000, 0, -32'sh0001_0000, 0, 0, 0, 0, 0,
                 0);
      offer_item(dctp_pkg::REQ_WALL_X, 32'h0032_0000, 32'h0001_0000, 0, 32'h0001_0000, 0, 0,
                 0, 0, 0);
      offer_item(dctp_pkg::REQ_WALL_Y, 0, 32'h0032_0000, 0, 32'h0003_0000, 0, 0, 0, 0, 0);
      offer_item(dctp_pkg::REQ_WALL_Y, 0, 32'h0032_0000, 0, -32'sh0003_0000, 0, 0, 0, 0, 0);
      offer_item(dctp_pkg::REQ_WALL_Y, 0, 32'h0032_0000, 32'h0001_0000, 0, 0, 0, 0, 0, 0);
      offer_item(dctp_pkg::REQ_WALL_Y, 0, 32'h8000_0000, 0, 1, 0, 0, 0, 0, 0);
      offer_item(dctp_pkg::REQ_WALL_Y, 0, 32'h7FFF_FFFF, 0, 32'h8000_0000, 0, 0, 0, 0, 0);
      offer_item(dctp_pkg::REQ_WALL_X, 32'h8000_0000, 0, 32'h7FFF_FFFF, 0, 0, 0, 0, 0, 0);
      // The unused request kind never hits.
      offer_item(dctp_pkg::REQ_UNUSED, 0, 0, 32'h0001_0000, 0, 32'h000A_0000, 0, 0, 0,
                 32'h0002_0000);

      // Random items under each register setting and each idling pattern.
      for (int s = 0; s < 5; s++) begin
         wait_until_drained();
         write_register(dctp_pkg::CSR_BOX_LENGTH, settings[s][0]);
         write_register(dctp_pkg::CSR_BOX_WIDTH, settings[s][1]);
         write_register(dctp_pkg::CSR_PARTICLE_RADIUS, settings[s][2]);
         for (int m = 0; m < 4; m++) begin
            gap_percent = gaps[m];
            stall_percent = stalls[m];
            // Under the first setting the receiver holds off for a long time
            // while the sender keeps offering items.
            if (s == 0 && m == 0) hold_off_cycles = 400;
            repeat (95) offer_random_item();
         end
      end

      gap_percent = 0;
      stall_percent = 0;
      wait_until_drained();
      if (mismatch_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
